FILE: sv/mts_pkg.sv
// Shared types, constants and saturating arithmetic helpers for the
// multilevel feedback queue scheduler; no dependencies.
package mts_pkg;

  localparam int MaxTasks  = 64;
  localparam int NumLevels = 8;
  localparam int SlotW     = $clog2(MaxTasks);
  localparam int LevelW    = $clog2(NumLevels);
  localparam int CntW      = SlotW + 1;
  localparam int TimeW     = 48;
  localparam int DefW      = 32;
  localparam int QuantW    = 31;
  localparam int RunW      = 24;
  localparam int RingDepth = MaxTasks * NumLevels;
  localparam int QmemDepth = RingDepth + MaxTasks;
  localparam int QaddrW    = $clog2(QmemDepth);

  // configuration register indexes
  localparam logic [1:0] CfgQuantum = 2'd0;
  localparam logic [1:0] CfgStarve  = 2'd1;
  localparam logic [1:0] CfgAging   = 2'd2;

  localparam logic [DefW-1:0] DefMax = {1'b0, {(DefW-1){1'b1}}};
  localparam logic [DefW-1:0] DefMin = {1'b1, {(DefW-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_FS_RD, S_FS_WR, S_TICK,
    S_AGE_LVL, S_AGE_RD, S_AGE_SLOT, S_AGE_DEC,
    S_SCAN_LVL, S_SCAN_RD, S_SCAN_SLOT, S_SCAN_DEC, S_SCAN_WB
  } state_e;

  // one access to the queue memory: a ring position or a free stack entry
  typedef struct packed {
    logic              en;
    logic              is_free;
    logic [LevelW-1:0] lv;
    logic [SlotW-1:0]  pos;
  } qreq_t;

  // deficit plus quantum, clamped at the positive limit
  function automatic logic [DefW-1:0] sat_add_q(logic [DefW-1:0] d, logic [QuantW-1:0] q);
    logic [DefW:0] s;
    s = {d[DefW-1], d} + {2'b00, q};
    if (s[DefW] == 1'b0 && s[DefW-1] == 1'b1) return DefMax;
    return s[DefW-1:0];
  endfunction

  // deficit minus run time, clamped at the negative limit
  function automatic logic [DefW-1:0] sat_sub_run(logic [DefW-1:0] d, logic [RunW-1:0] r);
    logic [DefW:0] s;
    s = {d[DefW-1], d} - {{(DefW-RunW+1){1'b0}}, r};
    if (s[DefW] == 1'b1 && s[DefW-1] == 1'b0) return DefMin;
    return s[DefW-1:0];
  endfunction

  // quantum of the next level: q + q/2, held at the positive limit
  function automatic logic [QuantW-1:0] next_quantum(logic [QuantW-1:0] q);
    logic [QuantW:0] s;
    s = {1'b0, q} + {2'b00, q[QuantW-1:1]};
    if (s[QuantW]) return {QuantW{1'b1}};
    return s[QuantW-1:0];
  endfunction

endpackage

FILE: sv/mlfq_drr_task_scheduler.sv
// Top level of the multilevel feedback queue scheduler with deficit round robin.
// Depends on mts_pkg and mts_queue_mem.
// A submit pops a slot off the free stack and pushes it on its ring, unless no slot is free;
// a tick may first run an aging pass over the tasks below level 0, then scans the levels in
// order and visits one ring entry at a time through the single read port of each memory.
// One request at a time; the result register must drain before the next.
// Reset is immediate: all slots free, all rings empty, aging disarmed.
module mlfq_drr_task_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [3:0]                    priority_req_i,
  input  logic [mts_pkg::TimeW-1:0]     now_us_i,
  input  logic [mts_pkg::RunW-1:0]      run_us_i,
  input  logic                          finished_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic [mts_pkg::SlotW-1:0]     task_slot_o,
  output logic [mts_pkg::LevelW-1:0]    run_level_o,
  output logic                          demoted_o,
  output logic                          released_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import mts_pkg::*;

  localparam logic [LevelW-1:0] LvLast = LevelW'(NumLevels - 1);

  state_e state_q, state_d;

  // configuration
  logic [19:0] quantum_base_q;
  logic [31:0] starve_q, aging_q;

  // latched request
  logic              fin_q;
  logic [LevelW-1:0] prio_q;
  logic [TimeW-1:0]  now_q;
  logic [RunW-1:0]   run_q;

  // scheduler control state
  logic [SlotW-1:0]  head_q [NumLevels];
  logic [CntW-1:0]   cnt_q  [NumLevels];
  logic [CntW-1:0]   free_cnt_q;
  logic [TimeW-1:0]  last_age_q;
  logic              armed_q;
  logic [LevelW-1:0] lv_q;
  logic [CntW-1:0]   rem_q;
  logic [QuantW-1:0] quant_q;
  logic [SlotW-1:0]  slot_q;
  logic [DefW-1:0]   def_q;

  // result register
  logic              out_valid_q, ok_q, dem_q, rel_q;
  logic [SlotW-1:0]  oslot_q;
  logic [LevelW-1:0] olvl_q;

  // per-slot memory: deficit and last run time
  logic [DefW+TimeW-1:0] smem [MaxTasks];
  logic [DefW+TimeW-1:0] s_rd_q;
  logic                  s_re, s_we;
  logic [SlotW-1:0]      s_addr;
  logic [DefW+TimeW-1:0] s_wdata;
  logic [DefW-1:0]       s_def;
  logic [TimeW-1:0]      s_last;

  // queue memory access
  qreq_t            q_rd, q_wr;
  logic [SlotW-1:0] q_wdata, q_rdata;

  // ring bookkeeping for the level in use this cycle
  logic [LevelW-1:0] acc_lv;
  logic              push, pop;

  // derived values
  logic [TimeW:0]    now_run;
  logic [TimeW-1:0]  fin_time;
  logic [DefW-1:0]   def_run;
  logic              promote, age_due;

  assign s_def  = s_rd_q[DefW+TimeW-1:TimeW];
  assign s_last = s_rd_q[TimeW-1:0];

  assign now_run  = {1'b0, now_q} + {{(TimeW-RunW+1){1'b0}}, run_q};
  assign fin_time = now_run[TimeW] ? {TimeW{1'b1}} : now_run[TimeW-1:0];
  assign def_run  = sat_sub_run(def_q, run_q);
  assign promote  = (now_q > s_last) && ((now_q - s_last) > {16'b0, starve_q});
  assign age_due  = (now_q > last_age_q) && ((now_q - last_age_q) > {16'b0, aging_q});

  mts_queue_mem u_qmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (q_rd),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rdata_o (q_rdata)
  );

  // slot memory with registered read
  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_addr] <= s_wdata;
    if (s_re) s_rd_q <= smem[s_addr];
  end

  // next state and memory requests
  always_comb begin
    state_d = state_q;
    acc_lv  = lv_q;
    push    = 1'b0;
    pop     = 1'b0;
    q_rd    = '0;
    q_wr    = '0;
    q_wdata = slot_q;
    s_re    = 1'b0;
    s_we    = 1'b0;
    s_addr  = slot_q;
    s_wdata = {s_def, s_last};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) state_d = func_i ? S_TICK : S_FS_RD;
      end
      S_FS_RD: begin
        if (free_cnt_q == '0) begin
          state_d = S_IDLE;
        end else begin
          q_rd.en      = 1'b1;
          q_rd.is_free = 1'b1;
          q_rd.pos     = SlotW'(free_cnt_q - 1'b1);
          state_d      = S_FS_WR;
        end
      end
      S_FS_WR: begin
        acc_lv   = prio_q;
        push     = 1'b1;
        q_wdata  = q_rdata;
        s_addr   = q_rdata;
        s_we     = 1'b1;
        s_wdata  = {{DefW{1'b0}}, now_q};
        state_d  = S_IDLE;
      end
      S_TICK: begin
        state_d = (armed_q && age_due) ? S_AGE_LVL : S_SCAN_LVL;
      end
      S_AGE_LVL: state_d = S_AGE_RD;
      S_AGE_RD: begin
        if (rem_q == '0) begin
          state_d = (lv_q == LvLast) ? S_SCAN_LVL : S_AGE_LVL;
        end else begin
          pop     = 1'b1;
          q_rd.en = 1'b1;
          q_rd.lv = lv_q;
          q_rd.pos = head_q[lv_q];
          state_d = S_AGE_SLOT;
        end
      end
      S_AGE_SLOT: begin
        s_re    = 1'b1;
        s_addr  = q_rdata;
        state_d = S_AGE_DEC;
      end
      S_AGE_DEC: begin
        push = 1'b1;
        if (promote) begin
          acc_lv  = lv_q - 1'b1;
          s_we    = 1'b1;
          s_wdata = {{DefW{1'b0}}, s_last};
        end
        state_d = S_AGE_RD;
      end
      S_SCAN_LVL: state_d = S_SCAN_RD;
      S_SCAN_RD: begin
        if (rem_q == '0) begin
          state_d = (lv_q == LvLast) ? S_IDLE : S_SCAN_LVL;
        end else begin
          pop     = 1'b1;
          q_rd.en = 1'b1;
          q_rd.lv = lv_q;
          q_rd.pos = head_q[lv_q];
          state_d = S_SCAN_SLOT;
        end
      end
      S_SCAN_SLOT: begin
        s_re    = 1'b1;
        s_addr  = q_rdata;
        state_d = S_SCAN_DEC;
      end
      S_SCAN_DEC: state_d = S_SCAN_WB;
      S_SCAN_WB: begin
        s_we = 1'b1;
        if (!def_q[DefW-1] && def_q != '0) begin
          // selected: charge run time, then free or requeue
          state_d = S_IDLE;
          if (fin_q) begin
            s_wdata      = {def_run, fin_time};
            q_wr.en      = 1'b1;
            q_wr.is_free = 1'b1;
            q_wr.pos     = SlotW'(free_cnt_q);
          end else if (def_run[DefW-1] && lv_q != LvLast) begin
            s_wdata = {{DefW{1'b0}}, fin_time};
            acc_lv  = lv_q + 1'b1;
            push    = 1'b1;
          end else begin
            s_wdata = {def_run, fin_time};
            push    = 1'b1;
          end
        end else begin
          s_wdata = {def_q, s_last};
          push    = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (push) begin
      q_wr.en      = 1'b1;
      q_wr.is_free = 1'b0;
      q_wr.lv      = acc_lv;
      q_wr.pos     = head_q[acc_lv] + cnt_q[acc_lv][SlotW-1:0];
    end
  end

  // state register and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      quantum_base_q <= 20'd10000;
      starve_q       <= 32'd1000000;
      aging_q        <= 32'd100000;
      free_cnt_q     <= CntW'(MaxTasks);
      last_age_q     <= '0;
      armed_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      for (int i = 0; i < NumLevels; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgQuantum: quantum_base_q <= cfg_data_i[19:0];
          CfgStarve:  starve_q       <= cfg_data_i;
          CfgAging:   aging_q        <= cfg_data_i;
          default:    ;
        endcase
      end

      // ring head and count updates
      if (pop) begin
        head_q[lv_q] <= head_q[lv_q] + 1'b1;
      end
      if (pop && !(push && acc_lv == lv_q)) begin
        cnt_q[lv_q] <= cnt_q[lv_q] - 1'b1;
      end else if (push && !(pop && acc_lv == lv_q)) begin
        cnt_q[acc_lv] <= cnt_q[acc_lv] + 1'b1;
      end

      if (state_q == S_FS_WR) free_cnt_q <= free_cnt_q - 1'b1;
      if (q_wr.en && q_wr.is_free) free_cnt_q <= free_cnt_q + 1'b1;

      // aging bookkeeping
      if (state_q == S_TICK) begin
        if (!armed_q) begin
          armed_q    <= 1'b1;
          last_age_q <= now_q;
        end else if (age_due) begin
          last_age_q <= now_q;
        end
      end

      // result register
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q != S_IDLE && state_d == S_IDLE) out_valid_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          prio_q <= (priority_req_i > 4'(NumLevels - 1)) ? LvLast
                                                           : LevelW'(priority_req_i);
          now_q  <= now_us_i;
          run_q  <= run_us_i;
          fin_q  <= finished_i;
        end
      end
      S_FS_RD: begin
        ok_q    <= 1'b0;
        oslot_q <= '0;
        olvl_q  <= '0;
        dem_q   <= 1'b0;
        rel_q   <= 1'b0;
      end
      S_FS_WR: begin
        ok_q    <= 1'b1;
        oslot_q <= q_rdata;
        olvl_q  <= prio_q;
      end
      S_TICK: begin
        ok_q    <= 1'b0;
        oslot_q <= '0;
        olvl_q  <= '0;
        dem_q   <= 1'b0;
        rel_q   <= 1'b0;
        quant_q <= QuantW'(quantum_base_q);
        lv_q    <= (armed_q && age_due) ? LevelW'(1) : '0;
      end
      S_AGE_LVL, S_SCAN_LVL: rem_q <= cnt_q[lv_q];
      S_AGE_RD: begin
        if (rem_q == '0) begin
          lv_q <= (lv_q == LvLast) ? '0 : lv_q + 1'b1;
        end else begin
          rem_q <= rem_q - 1'b1;
        end
      end
      S_SCAN_RD: begin
        if (rem_q == '0) begin
          lv_q    <= lv_q + 1'b1;
          quant_q <= next_quantum(quant_q);
        end else begin
          rem_q <= rem_q - 1'b1;
        end
      end
      S_AGE_SLOT, S_SCAN_SLOT: slot_q <= q_rdata;
      S_SCAN_DEC: def_q <= sat_add_q(s_def, quant_q);
      S_SCAN_WB: begin
        if (!def_q[DefW-1] && def_q != '0) begin
          ok_q    <= 1'b1;
          oslot_q <= slot_q;
          olvl_q  <= lv_q;
          rel_q   <= fin_q;
          dem_q   <= !fin_q && def_run[DefW-1] && lv_q != LvLast;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign task_slot_o = oslot_q;
  assign run_level_o = olvl_q;
  assign demoted_o   = dem_q;
  assign released_o  = rel_q;

endmodule

FILE: sv/mts_queue_mem.sv
// Queue memory: level rings and the free slot stack in one synchronous RAM.
// Depends on mts_pkg; free stack entries never written read as their index.
module mts_queue_mem (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mts_pkg::qreq_t       rd_i,
  input  mts_pkg::qreq_t       wr_i,
  input  logic [mts_pkg::SlotW-1:0] wdata_i,
  output logic [mts_pkg::SlotW-1:0] rdata_o
);
  import mts_pkg::*;

  logic [SlotW-1:0]  mem [QmemDepth];
  logic [MaxTasks-1:0] fvalid_q;
  logic [SlotW-1:0]  rd_raw_q;
  logic [SlotW-1:0]  rd_pos_q;
  logic              rd_dflt_q;
  logic [QaddrW-1:0] raddr, waddr;

  // map ring and free stack accesses onto the shared address space
  always_comb begin
    if (rd_i.is_free) raddr = QaddrW'(RingDepth) + QaddrW'(rd_i.pos);
    else              raddr = QaddrW'({rd_i.lv, rd_i.pos});
    if (wr_i.is_free) waddr = QaddrW'(RingDepth) + QaddrW'(wr_i.pos);
    else              waddr = QaddrW'({wr_i.lv, wr_i.pos});
  end

  // storage with registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[waddr] <= wdata_i;
    if (rd_i.en) begin
      rd_raw_q <= mem[raddr];
      rd_pos_q <= rd_i.pos;
    end
  end

  // free stack written flags and default-read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q  <= '0;
      rd_dflt_q <= 1'b0;
    end else begin
      if (wr_i.en && wr_i.is_free) fvalid_q[wr_i.pos] <= 1'b1;
      if (rd_i.en) rd_dflt_q <= rd_i.is_free && !fvalid_q[rd_i.pos];
    end
  end

  assign rdata_o = rd_dflt_q ? rd_pos_q : rd_raw_q;

endmodule
